// File: rtl/lc3ie_pkg.sv
// ----------------------------------------------------------------------------
// lc3ie_pkg
// Shared constants, types and helper functions of the LC-3 execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package lc3ie_pkg;

  localparam int MEM_WORDS  = 65536;
  localparam int STRING_CAP = 64;
  localparam int AW         = $clog2(MEM_WORDS);
  localparam int CW         = $clog2(STRING_CAP + 1);

  localparam logic [16:0] MEM_LIMIT    = 17'(MEM_WORDS);
  localparam logic [15:0] KBSR_ADDR    = 16'hFE00;
  localparam logic [15:0] KBDR_ADDR    = 16'hFE02;
  localparam logic [15:0] START_PC_RST = 16'h3000;
  localparam logic [15:0] KB_READY_VAL = 16'h8000;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [2:0] ST_EXEC    = 3'd0;
  localparam logic [2:0] ST_NOT_RUN = 3'd1;
  localparam logic [2:0] ST_HALT    = 3'd2;
  localparam logic [2:0] ST_LOADED  = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_RTI  = 4'h8;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_RSVD = 4'hD;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [7:0] VEC_GETC  = 8'h20;
  localparam logic [7:0] VEC_OUT   = 8'h21;
  localparam logic [7:0] VEC_PUTS  = 8'h22;
  localparam logic [7:0] VEC_IN    = 8'h23;
  localparam logic [7:0] VEC_PUTSP = 8'h24;
  localparam logic [7:0] VEC_HALT  = 8'h25;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_LD_WT, S_LDI_WT, S_LDI_RD,
    S_STI_WT, S_STI_WR, S_TRAP_R0, S_STR_RD, S_STR_WT, S_STR_LO, S_STR_HI,
    S_STR_END, S_DONE
  } state_t;

  typedef enum logic [1:0] {RK_NONE, RK_MEM, RK_KB, RK_ZERO} rd_kind_t;

  typedef struct packed {
    logic          en;
    logic          we;
    logic [AW-1:0] addr;
    logic [15:0]   wdata;
  } mem_req_t;

  typedef struct packed {
    logic        rd_en;
    logic [2:0]  ra_addr;
    logic [2:0]  rb_addr;
    logic        we;
    logic [2:0]  waddr;
    logic [15:0] wdata;
  } rf_req_t;

  function automatic logic [15:0] sext5(input logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic logic [15:0] sext6(input logic [5:0] v);
    return {{10{v[5]}}, v};
  endfunction

  function automatic logic [15:0] sext9(input logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [15:0] sext11(input logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'h0000) begin
      f = 3'b010;
    end else if (v[15]) begin
      f = 3'b100;
    end else begin
      f = 3'b001;
    end
    return f;
  endfunction

  function automatic logic in_range(input logic [15:0] a);
    return {1'b0, a} < MEM_LIMIT;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lc3ie_in_if.sv
// ----------------------------------------------------------------------------
// lc3ie_in_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lc3ie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] address;
  logic [15:0] data;
  logic        key_ready;
  logic [7:0]  key_char;

  modport source (
    output valid, req_type, address, data, key_ready, key_char,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, data, key_ready, key_char,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/lc3ie_out_if.sv
// ----------------------------------------------------------------------------
// lc3ie_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lc3ie_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] instr;
  logic [15:0] next_pc;
  logic [2:0]  cond_flags;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        is_running;
  logic        last;

  modport source (
    output valid, status, instr, next_pc, cond_flags, out_char, char_valid,
           is_running, last,
    input  ready
  );
  modport sink (
    input  valid, status, instr, next_pc, cond_flags, out_char, char_valid,
           is_running, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/lc3_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// lc3_instruction_execute_top
// LC-3 core: word memory, register file and an instruction sequencer.
// ----------------------------------------------------------------------------
// in_chan carries requests (load word, step one instruction, start); out_chan
// returns result transactions, several for PUTS/PUTSP (one per character, up
// to 64, last flagged). cfg_we/cfg_wdata write the start PC; write only while
// idle.
// After reset the block sweeps the word memory to zero, one word per cycle,
// and takes no request during the sweep.
// Every fetch, data access and keyboard poll goes in turn through the
// single-port word memory, whose read data is registered.
// One request is in flight at a time; the result register lets the next
// request be accepted while the last result still waits. When the receiver
// stalls, the result is held and a string trap pauses on its next character.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3_instruction_execute_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lc3ie_in_if.sink         in_chan,
  lc3ie_out_if.source      out_chan,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  lc3ie_pkg::mem_req_t mem_req;
  lc3ie_pkg::rf_req_t  rf_req;
  logic [15:0]         mem_q;
  logic [15:0]         rf_qa;
  logic [15:0]         rf_qb;

  lc3ie_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_q)
  );

  lc3ie_rf u_rf (
    .clk (clk),
    .req (rf_req),
    .qa  (rf_qa),
    .qb  (rf_qb)
  );

  lc3ie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .mem_q     (mem_q),
    .rf_req    (rf_req),
    .rf_qa     (rf_qa),
    .rf_qb     (rf_qb)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while a previous one is in progress");

  a_exec_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status == lc3ie_pkg::ST_EXEC ||
                       out_chan.status == lc3ie_pkg::ST_TRUNC) |-> out_chan.is_running)
    else $error("executed result while machine not running");

  a_nochar_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.char_valid |-> out_chan.last)
    else $error("non-final result without a character");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status == lc3ie_pkg::ST_TRUNC |->
      out_chan.last && out_chan.char_valid)
    else $error("truncation status on a non-final row");

endmodule

`default_nettype wire

// File: rtl/lc3ie_mem.sv
// ----------------------------------------------------------------------------
// lc3ie_mem
// Main word memory: single port, synchronous, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_mem (
  input  wire logic               clk,
  input  wire lc3ie_pkg::mem_req_t req,
  output logic [15:0]             rdata
);

  logic [15:0] mem [lc3ie_pkg::MEM_WORDS];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/lc3ie_rf.sv
// ----------------------------------------------------------------------------
// lc3ie_rf
// Register file: eight words, two registered read ports, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_rf (
  input  wire logic              clk,
  input  wire lc3ie_pkg::rf_req_t req,
  output logic [15:0]            qa,
  output logic [15:0]            qb
);

  logic [15:0] regs [8];

  always_ff @(posedge clk) begin
    if (req.we) begin
      regs[req.waddr] <= req.wdata;
    end
    if (req.rd_en) begin
      qa <= regs[req.ra_addr];
      qb <= regs[req.rb_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lc3ie_ctrl.sv
// ----------------------------------------------------------------------------
// lc3ie_ctrl
// Sequencer: fetch, decode, execute, string output and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  lc3ie_in_if.sink                 in_chan,
  lc3ie_out_if.source              out_chan,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata,
  output lc3ie_pkg::mem_req_t      mem_req,
  input  wire logic [15:0]         mem_q,
  output lc3ie_pkg::rf_req_t       rf_req,
  input  wire logic [15:0]         rf_qa,
  input  wire logic [15:0]         rf_qb
);

  localparam int AW = lc3ie_pkg::AW;
  localparam int CW = lc3ie_pkg::CW;

  lc3ie_pkg::state_t   state_r, state_nxt;
  lc3ie_pkg::rd_kind_t rk_r, rk_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [15:0]   pc_r, pc_nxt;
  logic [15:0]   ir_r, ir_nxt;
  logic [15:0]   instr_r, instr_nxt;
  logic [2:0]    flags_r, flags_nxt;
  logic          run_r, run_nxt;
  logic [15:0]   start_pc_r;
  logic          kr_r, kr_nxt;
  logic [7:0]    kc_r, kc_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic [15:0]   w_r, w_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic          trunc_r, trunc_nxt;
  logic          packed_r, packed_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          cv_r, cv_nxt;

  logic          ov_r;
  logic [2:0]    o_status_r;
  logic [15:0]   o_instr_r;
  logic [15:0]   o_pc_r;
  logic [2:0]    o_flags_r;
  logic [7:0]    o_char_r;
  logic          o_cv_r;
  logic          o_run_r;
  logic          o_last_r;

  logic          emit;
  logic [2:0]    e_status;
  logic [7:0]    e_char;
  logic          e_cv;
  logic          e_last;
  logic          out_free;

  logic          rd_go;
  logic [15:0]   rd_a;
  logic [15:0]   rd_val;
  logic [15:0]   alu_b;
  logic [15:0]   wv;
  logic [3:0]    opc;
  logic [3:0]    dec_opc;
  logic [2:0]    dr;
  logic [7:0]    trapv;
  logic [15:0]   pc_off9;
  logic [15:0]   ra_off6;
  logic          br_take;

  assign out_free = !ov_r || out_chan.ready;
  assign in_chan.ready = (state_r == lc3ie_pkg::S_IDLE);

  assign opc     = ir_r[15:12];
  assign dr      = ir_r[11:9];
  assign trapv   = ir_r[7:0];
  assign dec_opc = rd_val[15:12];
  assign pc_off9 = pc_r + lc3ie_pkg::sext9(ir_r[8:0]);
  assign ra_off6 = rf_qa + lc3ie_pkg::sext6(ir_r[5:0]);
  assign alu_b   = ir_r[5] ? lc3ie_pkg::sext5(ir_r[4:0]) : rf_qb;
  assign br_take = |(dr & flags_r);

  always_comb begin
    case (rk_r)
      lc3ie_pkg::RK_KB:   rd_val = kr_r ? lc3ie_pkg::KB_READY_VAL : 16'h0000;
      lc3ie_pkg::RK_MEM:  rd_val = mem_q;
      default:            rd_val = 16'h0000;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    pc_nxt     = pc_r;
    ir_nxt     = ir_r;
    instr_nxt  = instr_r;
    flags_nxt  = flags_r;
    run_nxt    = run_r;
    kr_nxt     = kr_r;
    kc_nxt     = kc_r;
    addr_nxt   = addr_r;
    w_nxt      = w_r;
    n_nxt      = n_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    trunc_nxt  = trunc_r;
    packed_nxt = packed_r;
    status_nxt = status_r;
    char_nxt   = char_r;
    cv_nxt     = cv_r;
    rk_nxt     = lc3ie_pkg::RK_NONE;
    rd_go      = 1'b0;
    rd_a       = 16'h0000;
    wv         = 16'h0000;
    emit       = 1'b0;
    e_status   = status_r;
    e_char     = char_r;
    e_cv       = cv_r;
    e_last     = 1'b1;
    mem_req    = '0;
    rf_req     = '0;

    // keyboard data word follows a status poll
    if (rk_r == lc3ie_pkg::RK_KB && kr_r && lc3ie_pkg::in_range(lc3ie_pkg::KBDR_ADDR)) begin
      mem_req.en    = 1'b1;
      mem_req.we    = 1'b1;
      mem_req.addr  = lc3ie_pkg::KBDR_ADDR[AW-1:0];
      mem_req.wdata = {8'h00, kc_r};
    end

    case (state_r)
      lc3ie_pkg::S_CLR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_r;
        mem_req.wdata = 16'h0000;
        rf_req.we     = 1'b1;
        rf_req.waddr  = clr_r[2:0];
        rf_req.wdata  = 16'h0000;
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == AW'(lc3ie_pkg::MEM_WORDS - 1)) begin
          state_nxt = lc3ie_pkg::S_IDLE;
        end
      end
      lc3ie_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          kr_nxt     = in_chan.key_ready;
          kc_nxt     = in_chan.key_char;
          instr_nxt  = 16'h0000;
          char_nxt   = 8'h00;
          cv_nxt     = 1'b0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          trunc_nxt  = 1'b0;
          state_nxt  = lc3ie_pkg::S_DONE;
          case (in_chan.req_type)
            lc3ie_pkg::REQ_LOAD: begin
              status_nxt = lc3ie_pkg::ST_LOADED;
              if (lc3ie_pkg::in_range(in_chan.address)) begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = in_chan.address[AW-1:0];
                mem_req.wdata = in_chan.data;
              end
            end
            lc3ie_pkg::REQ_START: begin
              status_nxt = lc3ie_pkg::ST_EXEC;
              pc_nxt     = start_pc_r;
              run_nxt    = 1'b1;
            end
            lc3ie_pkg::REQ_STEP: begin
              if (run_r) begin
                status_nxt = lc3ie_pkg::ST_EXEC;
                state_nxt  = lc3ie_pkg::S_FETCH;
              end else begin
                status_nxt = lc3ie_pkg::ST_NOT_RUN;
              end
            end
            default: begin
              status_nxt = lc3ie_pkg::ST_NOT_RUN;
            end
          endcase
        end
      end
      lc3ie_pkg::S_FETCH: begin
        rd_go     = 1'b1;
        rd_a      = pc_r;
        state_nxt = lc3ie_pkg::S_DECODE;
      end
      lc3ie_pkg::S_DECODE: begin
        ir_nxt         = rd_val;
        instr_nxt      = rd_val;
        pc_nxt         = pc_r + 16'd1;
        rf_req.rd_en   = 1'b1;
        rf_req.ra_addr = (dec_opc == lc3ie_pkg::OP_TRAP) ? 3'd0 : rd_val[8:6];
        rf_req.rb_addr = ((dec_opc == lc3ie_pkg::OP_ADD || dec_opc == lc3ie_pkg::OP_AND)
                          && !rd_val[5]) ? rd_val[2:0] : rd_val[11:9];
        state_nxt      = lc3ie_pkg::S_EXEC;
      end
      lc3ie_pkg::S_EXEC: begin
        state_nxt = lc3ie_pkg::S_DONE;
        case (opc)
          lc3ie_pkg::OP_BR: begin
            if (br_take) begin
              pc_nxt = pc_off9;
            end
          end
          lc3ie_pkg::OP_ADD, lc3ie_pkg::OP_AND, lc3ie_pkg::OP_NOT, lc3ie_pkg::OP_LEA: begin
            case (opc)
              lc3ie_pkg::OP_ADD: wv = rf_qa + alu_b;
              lc3ie_pkg::OP_AND: wv = rf_qa & alu_b;
              lc3ie_pkg::OP_NOT: wv = ~rf_qa;
              default:           wv = pc_off9;
            endcase
            rf_req.we    = 1'b1;
            rf_req.waddr = dr;
            rf_req.wdata = wv;
            flags_nxt    = lc3ie_pkg::flags_of(wv);
          end
          lc3ie_pkg::OP_LD: begin
            rd_go     = 1'b1;
            rd_a      = pc_off9;
            state_nxt = lc3ie_pkg::S_LD_WT;
          end
          lc3ie_pkg::OP_LDR: begin
            rd_go     = 1'b1;
            rd_a      = ra_off6;
            state_nxt = lc3ie_pkg::S_LD_WT;
          end
          lc3ie_pkg::OP_LDI: begin
            rd_go     = 1'b1;
            rd_a      = pc_off9;
            state_nxt = lc3ie_pkg::S_LDI_WT;
          end
          lc3ie_pkg::OP_STI: begin
            rd_go     = 1'b1;
            rd_a      = pc_off9;
            state_nxt = lc3ie_pkg::S_STI_WT;
          end
          lc3ie_pkg::OP_ST, lc3ie_pkg::OP_STR: begin
            wv = (opc == lc3ie_pkg::OP_ST) ? pc_off9 : ra_off6;
            if (lc3ie_pkg::in_range(wv)) begin
              mem_req.en    = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.addr  = wv[AW-1:0];
              mem_req.wdata = rf_qb;
            end
          end
          lc3ie_pkg::OP_JMP: begin
            pc_nxt = rf_qa;
          end
          lc3ie_pkg::OP_JSR: begin
            pc_nxt       = ir_r[11] ? pc_r + lc3ie_pkg::sext11(ir_r[10:0]) : rf_qa;
            rf_req.we    = 1'b1;
            rf_req.waddr = 3'd7;
            rf_req.wdata = pc_r;
          end
          lc3ie_pkg::OP_TRAP: begin
            rf_req.we    = 1'b1;
            rf_req.waddr = 3'd7;
            rf_req.wdata = pc_r;
            case (trapv)
              lc3ie_pkg::VEC_GETC, lc3ie_pkg::VEC_IN: begin
                state_nxt = lc3ie_pkg::S_TRAP_R0;
              end
              lc3ie_pkg::VEC_OUT: begin
                char_nxt = rf_qa[7:0];
                cv_nxt   = 1'b1;
              end
              lc3ie_pkg::VEC_PUTS, lc3ie_pkg::VEC_PUTSP: begin
                packed_nxt = (trapv == lc3ie_pkg::VEC_PUTSP);
                addr_nxt   = rf_qa;
                state_nxt  = lc3ie_pkg::S_STR_RD;
              end
              lc3ie_pkg::VEC_HALT: begin
                run_nxt    = 1'b0;
                status_nxt = lc3ie_pkg::ST_HALT;
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
      lc3ie_pkg::S_LD_WT: begin
        rf_req.we    = 1'b1;
        rf_req.waddr = dr;
        rf_req.wdata = rd_val;
        flags_nxt    = lc3ie_pkg::flags_of(rd_val);
        state_nxt    = lc3ie_pkg::S_DONE;
      end
      lc3ie_pkg::S_LDI_WT: begin
        addr_nxt  = rd_val;
        state_nxt = lc3ie_pkg::S_LDI_RD;
      end
      lc3ie_pkg::S_LDI_RD: begin
        rd_go     = 1'b1;
        rd_a      = addr_r;
        state_nxt = lc3ie_pkg::S_LD_WT;
      end
      lc3ie_pkg::S_STI_WT: begin
        addr_nxt  = rd_val;
        state_nxt = lc3ie_pkg::S_STI_WR;
      end
      lc3ie_pkg::S_STI_WR: begin
        if (lc3ie_pkg::in_range(addr_r)) begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = addr_r[AW-1:0];
          mem_req.wdata = rf_qb;
        end
        state_nxt = lc3ie_pkg::S_DONE;
      end
      lc3ie_pkg::S_TRAP_R0: begin
        rf_req.we    = 1'b1;
        rf_req.waddr = 3'd0;
        rf_req.wdata = {8'h00, kc_r};
        flags_nxt    = lc3ie_pkg::flags_of({8'h00, kc_r});
        state_nxt    = lc3ie_pkg::S_DONE;
      end
      lc3ie_pkg::S_STR_RD: begin
        rd_go     = 1'b1;
        rd_a      = addr_r;
        state_nxt = lc3ie_pkg::S_STR_WT;
      end
      lc3ie_pkg::S_STR_WT: begin
        w_nxt     = rd_val;
        state_nxt = lc3ie_pkg::S_STR_LO;
      end
      lc3ie_pkg::S_STR_LO: begin
        if (w_r == 16'h0000) begin
          state_nxt = lc3ie_pkg::S_STR_END;
        end else if (n_r == CW'(lc3ie_pkg::STRING_CAP)) begin
          trunc_nxt = 1'b1;
          state_nxt = lc3ie_pkg::S_STR_END;
        end else if (!pend_v_r || out_free) begin
          emit       = pend_v_r;
          e_char     = pend_r;
          e_cv       = 1'b1;
          e_last     = 1'b0;
          pend_nxt   = w_r[7:0];
          pend_v_nxt = 1'b1;
          n_nxt      = n_r + 1'b1;
          if (packed_r && w_r[15:8] != 8'h00) begin
            state_nxt = lc3ie_pkg::S_STR_HI;
          end else begin
            addr_nxt  = addr_r + 16'd1;
            state_nxt = lc3ie_pkg::S_STR_RD;
          end
        end
      end
      lc3ie_pkg::S_STR_HI: begin
        if (n_r == CW'(lc3ie_pkg::STRING_CAP)) begin
          trunc_nxt = 1'b1;
          state_nxt = lc3ie_pkg::S_STR_END;
        end else if (out_free) begin
          emit      = 1'b1;
          e_char    = pend_r;
          e_cv      = 1'b1;
          e_last    = 1'b0;
          pend_nxt  = w_r[15:8];
          n_nxt     = n_r + 1'b1;
          addr_nxt  = addr_r + 16'd1;
          state_nxt = lc3ie_pkg::S_STR_RD;
        end
      end
      lc3ie_pkg::S_STR_END: begin
        if (out_free) begin
          emit      = 1'b1;
          e_char    = pend_v_r ? pend_r : 8'h00;
          e_cv      = pend_v_r;
          e_status  = trunc_r ? lc3ie_pkg::ST_TRUNC : status_r;
          state_nxt = lc3ie_pkg::S_IDLE;
        end
      end
      lc3ie_pkg::S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = lc3ie_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lc3ie_pkg::S_IDLE;
      end
    endcase

    // memory read issue with keyboard poll and range handling
    if (rd_go) begin
      if (!lc3ie_pkg::in_range(rd_a)) begin
        rk_nxt = lc3ie_pkg::RK_ZERO;
      end else if (rd_a == lc3ie_pkg::KBSR_ADDR) begin
        rk_nxt        = lc3ie_pkg::RK_KB;
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = rd_a[AW-1:0];
        mem_req.wdata = kr_r ? lc3ie_pkg::KB_READY_VAL : 16'h0000;
      end else begin
        rk_nxt       = lc3ie_pkg::RK_MEM;
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b0;
        mem_req.addr = rd_a[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lc3ie_pkg::S_CLR;
      rk_r       <= lc3ie_pkg::RK_NONE;
      clr_r      <= '0;
      pc_r       <= 16'h0000;
      ir_r       <= 16'h0000;
      flags_r    <= 3'b000;
      run_r      <= 1'b0;
      start_pc_r <= lc3ie_pkg::START_PC_RST;
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rk_r    <= rk_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      ir_r    <= ir_nxt;
      flags_r <= flags_nxt;
      run_r   <= run_nxt;
      if (cfg_we) begin
        start_pc_r <= cfg_wdata;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    instr_r  <= instr_nxt;
    kr_r     <= kr_nxt;
    kc_r     <= kc_nxt;
    addr_r   <= addr_nxt;
    w_r      <= w_nxt;
    n_r      <= n_nxt;
    pend_r   <= pend_nxt;
    pend_v_r <= pend_v_nxt;
    trunc_r  <= trunc_nxt;
    packed_r <= packed_nxt;
    status_r <= status_nxt;
    char_r   <= char_nxt;
    cv_r     <= cv_nxt;
    if (emit) begin
      o_status_r <= e_status;
      o_instr_r  <= instr_r;
      o_pc_r     <= pc_r;
      o_flags_r  <= flags_r;
      o_char_r   <= e_cv ? e_char : 8'h00;
      o_cv_r     <= e_cv;
      o_run_r    <= run_r;
      o_last_r   <= e_last;
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.status     = o_status_r;
  assign out_chan.instr      = o_instr_r;
  assign out_chan.next_pc    = o_pc_r;
  assign out_chan.cond_flags = o_flags_r;
  assign out_chan.out_char   = o_char_r;
  assign out_chan.char_valid = o_cv_r;
  assign out_chan.is_running = o_run_r;
  assign out_chan.last       = o_last_r;

endmodule

`default_nettype wire

// File: tb/tb_lc3ie_if.sv
// ----------------------------------------------------------------------------
// tb_lc3ie_if
// Testbench-side handle on the request and result channels.
// ----------------------------------------------------------------------------
// The channel interfaces themselves come with the RTL (lc3ie_in_if and
// lc3ie_out_if). This file only holds the packed record types that the
// testbench uses for stimulus rows and expected results.
// ----------------------------------------------------------------------------
package tb_lc3ie_types;
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [15:0] data;
    logic        key_ready;
    logic [7:0]  key_char;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] instr;
    logic [15:0] next_pc;
    logic [2:0]  cond_flags;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        is_running;
    logic        last;
  } res_t;
endpackage

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the LC-3 execute block.
// ----------------------------------------------------------------------------
// Runs a directed table (load, start, step, error cases) and then random
// programs built from every opcode and trap, with random idling on both
// channels. Every result transaction is checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lc3ie_pkg::*;
  import tb_lc3ie_types::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  lc3ie_in_if  in_chan();
  lc3ie_out_if out_chan();

  lc3_instruction_execute_top dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // model state
  logic [15:0] mem_m [0:MEM_WORDS-1];
  logic [15:0] regs_m [0:7];
  logic [15:0] pc_m;
  logic [2:0]  flags_m;
  logic        run_m;
  logic [15:0] start_pc_m;
  logic        kb_rdy_m;
  logic [7:0]  kb_chr_m;

  res_t exp_q[$];
  int   errors = 0;
  int   n_results = 0;
  int   n_items = 0;
  int   n_strings = 0;
  bit   no_idle = 0;

  function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
    logic [15:0] m;
    m = (16'h1 << bits) - 16'h1;
    return (v[bits-1]) ? (v | ~m) : (v & m);
  endfunction

  function automatic logic [15:0] rd_word(input logic [15:0] a);
    if ({1'b0, a} >= 17'(MEM_WORDS)) return 16'h0;
    if (a == KBSR_ADDR) begin
      if (kb_rdy_m) begin
        mem_m[a] = KB_READY_VAL;
        mem_m[KBDR_ADDR] = {8'h0, kb_chr_m};
      end else begin
        mem_m[a] = 16'h0;
      end
    end
    return mem_m[a];
  endfunction

  function automatic void wr_word(input logic [15:0] a, input logic [15:0] v);
    if ({1'b0, a} < 17'(MEM_WORDS)) mem_m[a] = v;
  endfunction

  function automatic logic [2:0] nzp(input logic [15:0] v);
    if (v == 16'h0) return 3'b010;
    if (v[15]) return 3'b100;
    return 3'b001;
  endfunction

  // compute expected results of one request and queue them
  function automatic void predict_exec(input req_t r);
    logic [7:0]  chars [$];
    logic        trunc;
    logic [2:0]  st;
    logic [15:0] ins, ir, pc, t, a, w;
    logic [2:0]  dr, sr1;
    logic        packed_s;
    int          rows;
    res_t        e;
    trunc = 0; st = ST_EXEC; ins = '0;
    kb_rdy_m = r.key_ready;
    kb_chr_m = r.key_char;
    if (r.req_type == REQ_LOAD) begin
      wr_word(r.address, r.data);
      st = ST_LOADED;
    end else if (r.req_type == REQ_START) begin
      pc_m = start_pc_m;
      run_m = 1;
    end else if (r.req_type != REQ_STEP || !run_m) begin
      st = ST_NOT_RUN;
    end else begin
      ir = rd_word(pc_m);
      ins = ir;
      pc_m = pc_m + 16'h1;
      pc = pc_m;
      dr = ir[11:9];
      sr1 = ir[8:6];
      case (ir[15:12])
        OP_BR: if ((dr & flags_m) != 3'b0) pc_m = pc + sx(ir, 9);
        OP_ADD: begin
          t = ir[5] ? sx(ir, 5) : regs_m[ir[2:0]];
          regs_m[dr] = regs_m[sr1] + t; flags_m = nzp(regs_m[dr]);
        end
        OP_AND: begin
          t = ir[5] ? sx(ir, 5) : regs_m[ir[2:0]];
          regs_m[dr] = regs_m[sr1] & t; flags_m = nzp(regs_m[dr]);
        end
        OP_NOT: begin regs_m[dr] = ~regs_m[sr1]; flags_m = nzp(regs_m[dr]); end
        OP_LD: begin regs_m[dr] = rd_word(pc + sx(ir, 9)); flags_m = nzp(regs_m[dr]); end
        OP_LDI: begin
          t = rd_word(pc + sx(ir, 9));
          regs_m[dr] = rd_word(t); flags_m = nzp(regs_m[dr]);
        end
        OP_LDR: begin
          regs_m[dr] = rd_word(regs_m[sr1] + sx(ir, 6)); flags_m = nzp(regs_m[dr]);
        end
        OP_LEA: begin regs_m[dr] = pc + sx(ir, 9); flags_m = nzp(regs_m[dr]); end
        OP_ST: wr_word(pc + sx(ir, 9), regs_m[dr]);
        OP_STI: begin t = rd_word(pc + sx(ir, 9)); wr_word(t, regs_m[dr]); end
        OP_STR: wr_word(regs_m[sr1] + sx(ir, 6), regs_m[dr]);
        OP_JMP: pc_m = regs_m[sr1];
        OP_JSR: begin
          if (ir[11]) pc_m = pc + sx(ir, 11);
          else pc_m = regs_m[sr1];
          regs_m[7] = pc;
        end
        OP_TRAP: begin
          regs_m[7] = pc;
          case (ir[7:0])
            VEC_GETC, VEC_IN: begin
              regs_m[0] = {8'h0, kb_chr_m}; flags_m = nzp(regs_m[0]);
            end
            VEC_OUT: chars.push_back(regs_m[0][7:0]);
            VEC_PUTS, VEC_PUTSP: begin
              packed_s = (ir[7:0] == VEC_PUTSP);
              a = regs_m[0];
              n_strings++;
              forever begin
                w = rd_word(a);
                if (w == 16'h0) break;
                if (chars.size() >= STRING_CAP) begin trunc = 1; break; end
                chars.push_back(w[7:0]);
                if (packed_s && w[15:8] != 8'h0) begin
                  if (chars.size() >= STRING_CAP) begin trunc = 1; break; end
                  chars.push_back(w[15:8]);
                end
                a = a + 16'h1;
              end
            end
            VEC_HALT: begin run_m = 0; st = ST_HALT; end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    rows = chars.size() > 0 ? chars.size() : 1;
    for (int i = 0; i < rows; i++) begin
      e.last = (i == rows - 1);
      e.status = (e.last && trunc) ? ST_TRUNC : st;
      e.instr = ins;
      e.next_pc = pc_m;
      e.cond_flags = flags_m;
      e.out_char = chars.size() > 0 ? chars[i] : 8'h0;
      e.char_valid = chars.size() > 0;
      e.is_running = run_m;
      exp_q.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------- driving
  initial begin
    in_chan.valid = 0; in_chan.req_type = '0; in_chan.address = '0;
    in_chan.data = '0; in_chan.key_ready = 0; in_chan.key_char = '0;
    out_chan.ready = 0;
  end

  task automatic send(input req_t r);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.req_type <= r.req_type; in_chan.address <= r.address;
    in_chan.data <= r.data; in_chan.key_ready <= r.key_ready;
    in_chan.key_char <= r.key_char;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_exec(r);
    n_items++;
  endtask

  task automatic idle_in();
    in_chan.valid <= 1'b0;
  endtask

  // wait until every result has come, then the block's internal tail
  task automatic drain();
    idle_in();
    while (exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_start(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_pc_m = v;
  endtask

  function automatic req_t mk(input logic [1:0] t, input logic [15:0] a,
                              input logic [15:0] d, input logic kr,
                              input logic [7:0] kc);
    req_t r;
    r.req_type = t; r.address = a; r.data = d; r.key_ready = kr; r.key_char = kc;
    return r;
  endfunction

  task automatic ld(input logic [15:0] a, input logic [15:0] d);
    send(mk(REQ_LOAD, a, d, 1'($urandom_range(0, 1)), 8'($urandom)));
  endtask

  task automatic stp();
    send(mk(REQ_STEP, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
            8'($urandom)));
  endtask

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    logic [3:0]  ops [14];
    logic [7:0]  tv;
    ops = '{OP_BR, OP_ADD, OP_LD, OP_ST, OP_JSR, OP_AND, OP_LDR, OP_STR,
            OP_NOT, OP_LDI, OP_STI, OP_JMP, OP_LEA, OP_TRAP};
    w = 16'($urandom);
    w[15:12] = ops[$urandom_range(0, 13)];
    if ($urandom_range(0, 20) == 0) w[15:12] = $urandom_range(0, 1) ? OP_RTI : OP_RSVD;
    if (w[15:12] == OP_TRAP) begin
      case ($urandom_range(0, 7))
        0: tv = VEC_GETC; 1: tv = VEC_OUT; 2: tv = VEC_PUTS; 3: tv = VEC_IN;
        4: tv = VEC_PUTSP; 5: tv = VEC_HALT; default: tv = 8'($urandom);
      endcase
      w[7:0] = tv;
    end
    // keep most memory traffic near the program so loads see written words
    if (w[15:12] inside {OP_LD, OP_ST, OP_LDI, OP_STI, OP_LEA, OP_BR} &&
        $urandom_range(0, 3) != 0) w[8:0] = 9'($urandom_range(0, 15));
    return w;
  endfunction

  // directed table; known marks rows whose result is typed in
  typedef struct {
    req_t r;
    bit   known;
    res_t e;
  } row_t;

  row_t tbl [$];

  task automatic add_row(input req_t r, input bit k, input res_t e);
    row_t x;
    x.r = r; x.known = k; x.e = e;
    tbl.push_back(x);
  endtask

  function automatic res_t rs(input logic [2:0] s, input logic [15:0] pc,
                              input logic [2:0] f, input logic run);
    res_t e;
    e = '0; e.status = s; e.next_pc = pc; e.cond_flags = f; e.is_running = run;
    e.last = 1;
    return e;
  endfunction

  initial begin
    res_t z;
    int base;
    int len;
    logic [15:0] w;
    z = '0;
    for (int i = 0; i < MEM_WORDS; i++) mem_m[i] = '0;
    for (int i = 0; i < 8; i++) regs_m[i] = '0;
    pc_m = '0; flags_m = '0; run_m = 0; start_pc_m = START_PC_RST;
    kb_rdy_m = 0; kb_chr_m = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ------------------------------------------------------------ directed
    add_row(mk(REQ_STEP, 16'hFFFF, 16'hFFFF, 1, 8'hFF), 1, rs(ST_NOT_RUN, 0, 0, 0));
    add_row(mk(REQ_RSVD, 16'h0, 16'h0, 0, 8'h0), 1, rs(ST_NOT_RUN, 0, 0, 0));
    add_row(mk(REQ_LOAD, 16'hFFFF, 16'hFFFF, 0, 8'h0), 1, rs(ST_LOADED, 0, 0, 0));
    add_row(mk(REQ_LOAD, 16'h0000, 16'h0000, 1, 8'hFF), 1, rs(ST_LOADED, 0, 0, 0));
    // program at 0x3000
    add_row(mk(REQ_LOAD, 16'h3000, 16'h1020 | 16'h001F, 0, 0), 0, z); // ADD R0,R0,#-1
    add_row(mk(REQ_LOAD, 16'h3001, 16'h5020, 0, 0), 0, z);             // AND R0,R0,#0
    add_row(mk(REQ_LOAD, 16'h3002, 16'h927F, 0, 0), 0, z);             // NOT R1,R1
    add_row(mk(REQ_LOAD, 16'h3003, 16'hE208, 0, 0), 0, z);             // LEA R1,#8
    add_row(mk(REQ_LOAD, 16'h3004, 16'hF023, 0, 0), 0, z);             // IN
    add_row(mk(REQ_LOAD, 16'h3005, 16'hF021, 0, 0), 0, z);             // OUT
    add_row(mk(REQ_LOAD, 16'h3006, 16'hE002, 0, 0), 0, z);             // LEA R0,str
    add_row(mk(REQ_LOAD, 16'h3007, 16'hF024, 0, 0), 0, z);             // PUTSP
    add_row(mk(REQ_LOAD, 16'h3008, 16'hF025, 0, 0), 0, z);             // HALT
    add_row(mk(REQ_LOAD, 16'h3009, 16'h0041, 0, 0), 0, z);
    add_row(mk(REQ_LOAD, 16'h300A, 16'h4342, 0, 0), 0, z);
    add_row(mk(REQ_START, 16'h0, 16'h0, 0, 0), 1, rs(ST_EXEC, 16'h3000, 0, 1));
    for (int i = 0; i < 9; i++)
      add_row(mk(REQ_STEP, 16'h0, 16'h0, i[0], 8'h80 | 8'(i)), 0, z);
    foreach (tbl[i]) begin
      send(tbl[i].r);
      if (tbl[i].known) begin
        if (exp_q.size() == 0 || exp_q[$] != tbl[i].e) begin
          $error("directed row %0d: table expectation %h, model %h", i,
                 tbl[i].e, exp_q[$]);
          errors++;
        end
      end
    end

    // long string (truncation) and an empty string, plus keyboard polling
    set_start(16'h0100);
    for (int i = 0; i < 70; i++) ld(16'h0200 + 16'(i), 16'h0040 + 16'(i % 20) + 16'h1);
    ld(16'h0100, 16'hE0FF); // LEA R0 -> 0x0200
    ld(16'h0101, 16'h2005); // LD R0, [0x0107] = 0x0200
    ld(16'h0102, 16'hF022); // PUTS (truncated)
    ld(16'h0103, 16'h2205); // LD R1 ,[0x0109] = 0
    ld(16'h0104, 16'hA005); // LDI R0, [[0x010A]] -> KBSR poll
    ld(16'h0105, 16'h5020); // AND R0,#0 -> R0=0
    ld(16'h0106, 16'hF024); // PUTSP at 0 -> word at 0 is 0: empty
    ld(16'h0107, 16'h0200);
    ld(16'h010A, KBSR_ADDR);
    ld(16'h0000, 16'h0000);
    send(mk(REQ_START, 0, 0, 0, 0));
    for (int i = 0; i < 7; i++) send(mk(REQ_STEP, 0, 0, i[0], 8'h41 + 8'(i)));

    // --------------------------------------------------------------- random
    for (int blk = 0; blk < 8; blk++) begin
      case (blk)
        0: set_start(16'hFFFF);
        1: set_start(16'h0000);
        default: set_start(16'($urandom_range(0, 16'h7FFF)) & 16'h7F00);
      endcase
      if (blk == 6) no_idle = 1;
      base = start_pc_m;
      len = $urandom_range(6, 14);
      for (int i = 0; i < len; i++) ld(16'(base + i), rand_instr());
      // data/string words after the program
      for (int i = 0; i < 8; i++) begin
        w = $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom);
        ld(16'(base + len + i), w);
      end
      if ($urandom_range(0, 1)) ld(16'($urandom), 16'($urandom));
      if ($urandom_range(0, 3) == 0) stp(); // may be not running
      send(mk(REQ_START, 16'($urandom), 16'($urandom), 0, 0));
      for (int i = 0; i < len + 2; i++) begin
        if ($urandom_range(0, 15) == 0) send(mk(REQ_RSVD, 16'($urandom), 0, 0, 0));
        stp();
      end
      if (blk == 4) drain();
    end
    drain();
    $display("covered %0d requests, %0d string traps, %0d result transactions",
             n_items, n_strings, n_results);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- sink side
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 19);
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t g, e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      g.status = out_chan.status; g.instr = out_chan.instr;
      g.next_pc = out_chan.next_pc; g.cond_flags = out_chan.cond_flags;
      g.out_char = out_chan.out_char; g.char_valid = out_chan.char_valid;
      g.is_running = out_chan.is_running; g.last = out_chan.last;
      n_results++;
      if (exp_q.size() == 0) begin
        $error("unexpected result transaction %h", g);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (g.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, g.status); errors++; end
        if (g.instr !== e.instr) begin
          $error("instr exp %h got %h", e.instr, g.instr); errors++; end
        if (g.next_pc !== e.next_pc) begin
          $error("next_pc exp %h got %h", e.next_pc, g.next_pc); errors++; end
        if (g.cond_flags !== e.cond_flags) begin
          $error("cond_flags exp %b got %b", e.cond_flags, g.cond_flags); errors++; end
        if (g.out_char !== e.out_char) begin
          $error("out_char exp %h got %h", e.out_char, g.out_char); errors++; end
        if (g.char_valid !== e.char_valid) begin
          $error("char_valid exp %b got %b", e.char_valid, g.char_valid); errors++; end
        if (g.is_running !== e.is_running) begin
          $error("is_running exp %b got %b", e.is_running, g.is_running); errors++; end
        if (g.last !== e.last) begin
          $error("last exp %b got %b", e.last, g.last); errors++; end
      end
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
